// ===== design/rqr_pkg.sv =====
// ----------------------------------------------------------------------------
// rqr_pkg: shared types and constants of the ready queue with remove
// Queue sizes, action and status codes, and the control word that is
// broadcast to every queue cell.
// ----------------------------------------------------------------------------
package rqr_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ID_WIDTH    = 8;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_YIELD = 2'd1,
    ACT_TERM  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_e;

  // Broadcast to all cells each cycle
  typedef struct packed {
    logic                shift;  // take the right-hand neighbor's entry
    logic                load;   // the cell at pos takes data
    logic [IDX_W-1:0]    pos;
    logic [ID_WIDTH-1:0] data;
  } cell_ctl_t;

endpackage

// ===== design/rqr_cell.sv =====
// ----------------------------------------------------------------------------
// rqr_cell: one queue slot
// Holds one thread id. Loads the broadcast id when addressed, otherwise
// takes its right-hand neighbor's entry on a shift, otherwise holds.
// ----------------------------------------------------------------------------
module rqr_cell (
  input  logic                          clk_i,
  input  logic [rqr_pkg::IDX_W-1:0]     idx_i,
  input  rqr_pkg::cell_ctl_t            ctl_i,
  input  logic [rqr_pkg::ID_WIDTH-1:0]  nbr_i,
  output logic [rqr_pkg::ID_WIDTH-1:0]  data_o
);

  logic [rqr_pkg::ID_WIDTH-1:0] data_d, data_q;

  always_comb begin
    priority if (ctl_i.load && (ctl_i.pos == idx_i)) begin
      data_d = ctl_i.data;
    end else if (ctl_i.shift) begin
      data_d = nbr_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== design/ready_queue_with_remove_unit.sv =====
// ----------------------------------------------------------------------------
// ready_queue_with_remove_unit: FIFO ready queue of thread ids with delete
// A row of queue cells, cell 0 at the head, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries action_i and
//   thread_id_i: add at tail, yield (pop head), terminate (remove every
//   entry equal to the id). Output channel (out_valid_o / out_ready_i)
//   returns one result per item: status, dispatched id, removed count and
//   the occupancy after the item.
//   Add, yield and the unused action finish in the transfer cycle; the
//   result is registered and valid in the next cycle. Terminate walks the
//   queued entries through the cell row, one entry per cycle; on an empty
//   queue it finishes in the transfer cycle like the other actions.
//   Entries that survive are rotated back to the tail, so their order
//   holds once the walk ends.
//   One item is in work at a time; a new item is taken while the previous
//   result is being transferred out in the same cycle.
//   Reset empties the queue (count to zero, no cell contents cleared) and
//   drops any pending result. When the receiver stalls, the result is
//   held in the output register and no new item is taken.
// ----------------------------------------------------------------------------
module ready_queue_with_remove_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [rqr_pkg::ID_WIDTH-1:0]  thread_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [rqr_pkg::ID_WIDTH-1:0]  dispatched_id_o,
  output logic                          dispatch_valid_o,
  output logic [4:0]                    removed_count_o,
  output logic [4:0]                    occupancy_o
);

  localparam int unsigned IDX_W = rqr_pkg::IDX_W;
  localparam int unsigned CNT_W = rqr_pkg::CNT_W;
  localparam int unsigned IDW   = rqr_pkg::ID_WIDTH;
  localparam int unsigned DEPTH = rqr_pkg::QUEUE_DEPTH;

  rqr_pkg::state_e    state_d, state_q;
  logic [CNT_W-1:0]   count_d, count_q;
  logic [CNT_W-1:0]   rem_d, rem_q;
  logic [CNT_W-1:0]   kept_d, kept_q;
  logic [IDW-1:0]     id_d, id_q;
  logic [CNT_W-1:0]   pos_sum;
  logic               keep;

  rqr_pkg::cell_ctl_t ctl;
  logic [IDW-1:0]     cell_data [DEPTH];

  logic               in_fire;
  logic               res_ld;
  rqr_pkg::status_e   res_status;
  logic [IDW-1:0]     res_disp_id;
  logic               res_disp_vld;
  logic [CNT_W-1:0]   res_removed;

  logic               out_valid_q;
  rqr_pkg::status_e   status_q;
  logic [IDW-1:0]     disp_id_q;
  logic               disp_vld_q;
  logic [CNT_W-1:0]   removed_q;
  logic [CNT_W-1:0]   occ_q;

  // Cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [IDW-1:0] nbr;
    if (g == DEPTH - 1) begin : g_last
      assign nbr = cell_data[g];
    end else begin : g_mid
      assign nbr = cell_data[g+1];
    end
    rqr_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (IDX_W'(g)),
      .ctl_i  (ctl),
      .nbr_i  (nbr),
      .data_o (cell_data[g])
    );
  end

  assign in_ready_o = (state_q == rqr_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // During a walk, unexamined entries sit in [0, rem) and kept ones in
  // [rem, rem+kept); after the shift the kept head goes to rem-1+kept.
  assign keep    = (cell_data[0] != id_q);
  assign pos_sum = rem_q + kept_q - CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rem_d        = rem_q;
    kept_d       = kept_q;
    id_d         = id_q;
    ctl.shift    = 1'b0;
    ctl.load     = 1'b0;
    ctl.pos      = '0;
    ctl.data     = thread_id_i;
    res_ld       = 1'b0;
    res_status   = rqr_pkg::STATUS_OK;
    res_disp_id  = '0;
    res_disp_vld = 1'b0;
    res_removed  = '0;

    unique case (state_q)
      rqr_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (action_i)
            rqr_pkg::ACT_ADD: begin
              res_ld = 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                res_status = rqr_pkg::STATUS_FULL;
              end else begin
                ctl.load = 1'b1;
                ctl.pos  = count_q[IDX_W-1:0];
                count_d  = count_q + CNT_W'(1);
              end
            end
            rqr_pkg::ACT_YIELD: begin
              res_ld = 1'b1;
              if (count_q == '0) begin
                res_status = rqr_pkg::STATUS_EMPTY;
              end else begin
                res_disp_id  = cell_data[0];
                res_disp_vld = 1'b1;
                ctl.shift    = 1'b1;
                count_d      = count_q - CNT_W'(1);
              end
            end
            rqr_pkg::ACT_TERM: begin
              if (count_q == '0) begin
                res_ld = 1'b1;
              end else begin
                state_d = rqr_pkg::ST_WALK;
                rem_d   = count_q;
                kept_d  = '0;
                id_d    = thread_id_i;
              end
            end
            default: begin
              res_ld = 1'b1;
            end
          endcase
        end
      end
      rqr_pkg::ST_WALK: begin
        ctl.shift = 1'b1;
        ctl.load  = keep;
        ctl.pos   = pos_sum[IDX_W-1:0];
        ctl.data  = cell_data[0];
        rem_d     = rem_q - CNT_W'(1);
        if (keep) begin
          kept_d = kept_q + CNT_W'(1);
        end
        if (rem_q == CNT_W'(1)) begin
          state_d     = rqr_pkg::ST_IDLE;
          count_d     = kept_d;
          res_ld      = 1'b1;
          res_removed = count_q - kept_d;
        end
      end
      default: begin
        state_d = rqr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rqr_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (res_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    kept_q <= kept_d;
    id_q   <= id_d;
    if (res_ld) begin
      status_q   <= res_status;
      disp_id_q  <= res_disp_id;
      disp_vld_q <= res_disp_vld;
      removed_q  <= res_removed;
      occ_q      <= count_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign dispatched_id_o  = disp_id_q;
  assign dispatch_valid_o = disp_vld_q;
  assign removed_count_o  = 5'(removed_q);
  assign occupancy_o      = 5'(occ_q);

endmodule

// ===== design/rqr_checker.sv =====
// ----------------------------------------------------------------------------
// rqr_checker: port-level checks of the ready queue with remove
// Watches the result channel for handshake and consistency of the fields.
// ----------------------------------------------------------------------------
module rqr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [1:0]                    status_o,
  input logic [rqr_pkg::ID_WIDTH-1:0]  dispatched_id_o,
  input logic                          dispatch_valid_o,
  input logic [4:0]                    removed_count_o,
  input logic [4:0]                    occupancy_o
);

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(dispatched_id_o) && $stable(occupancy_o) && $stable(removed_count_o))
    else $error("result changed while stalled");

  // Idle dispatch leaves an empty queue and no id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == rqr_pkg::STATUS_EMPTY) |->
      (occupancy_o == 5'd0) && !dispatch_valid_o && (dispatched_id_o == '0))
    else $error("empty yield with nonzero occupancy or id");

  // A dropped add only happens on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == rqr_pkg::STATUS_FULL) |->
      (occupancy_o == 5'(rqr_pkg::QUEUE_DEPTH)) && (removed_count_o == 5'd0))
    else $error("full status with queue not full");

  // Occupancy and removal never exceed the depth together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (6'(occupancy_o) + 6'(removed_count_o)) <= 6'(rqr_pkg::QUEUE_DEPTH))
    else $error("occupancy plus removed beyond depth");

endmodule

bind ready_queue_with_remove_unit rqr_checker u_rqr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .dispatched_id_o  (dispatched_id_o),
  .dispatch_valid_o (dispatch_valid_o),
  .removed_count_o  (removed_count_o),
  .occupancy_o      (occupancy_o)
);

// ===== sim/ready_queue_with_remove_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ready_queue_with_remove_unit_test: self-checking bench for the ready queue
// Walks a short table of directed items (empty and full queue, extreme ids,
// unused action, whole-queue terminate), then random scheduler traffic in
// three idling phases. A shadow queue of ids tracks every item and predicts the results that the table does not give.
// ----------------------------------------------------------------------------
module ready_queue_with_remove_unit_test;

  localparam int unsigned IDW          = rqr_pkg::ID_WIDTH;
  localparam logic [1:0] ACT_UNUSED        = 2'd3;
  localparam int         PHASE_ITEMS       = 584;
  localparam int         DIRECTED_ROWS     = 10;
  localparam int         LONG_STALL_AT     = 25 + 2 * PHASE_ITEMS + 60;
  localparam int         LONG_STALL_CYCLES = 300;
  localparam int         TAIL_CYCLES       = 20;  // idle clocks after the last result

  typedef struct packed {
    rqr_pkg::status_e    status;
    logic [IDW-1:0]      disp_id;
    logic                disp_valid;
    logic [4:0]          removed;
    logic [4:0]          occupancy;
  } sched_result_t;

  typedef struct {
    logic [1:0]          act;
    logic [IDW-1:0]      id;
    int                  reps;
    bit                  typed;
    sched_result_t       want;
  } directed_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          action;
  logic [IDW-1:0]      thread_id;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          status;
  logic [IDW-1:0]      dispatched_id;
  logic                dispatch_valid;
  logic [4:0]          removed_count;
  logic [4:0]          occupancy;

  logic [IDW-1:0]      ready_ids[$];        // shadow of the queue, head first
  sched_result_t       pending_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int items_accepted;
  int results_seen;
  int dispatches;
  int full_drops;
  int removals;
  int max_removed;
  bit long_stall_done;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{rqr_pkg::ACT_YIELD, 8'h00, 1,  1'b1, '{rqr_pkg::STATUS_EMPTY, 8'h00, 1'b0, 5'd0,  5'd0}},
    '{rqr_pkg::ACT_TERM,  8'h00, 1,  1'b1, '{rqr_pkg::STATUS_OK,    8'h00, 1'b0, 5'd0,  5'd0}},
    '{ACT_UNUSED,         8'hAA, 1,  1'b1, '{rqr_pkg::STATUS_OK,    8'h00, 1'b0, 5'd0,  5'd0}},
    '{rqr_pkg::ACT_ADD,   8'hFF, 16, 1'b0, '{rqr_pkg::STATUS_OK,    8'h00, 1'b0, 5'd0,  5'd0}},
    '{rqr_pkg::ACT_ADD,   8'h00, 1,  1'b1, '{rqr_pkg::STATUS_FULL,  8'h00, 1'b0, 5'd0,  5'd16}},
    '{ACT_UNUSED,         8'h55, 1,  1'b1, '{rqr_pkg::STATUS_OK,    8'h00, 1'b0, 5'd0,  5'd16}},
    '{rqr_pkg::ACT_TERM,  8'h00, 1,  1'b1, '{rqr_pkg::STATUS_OK,    8'h00, 1'b0, 5'd0,  5'd16}},
    '{rqr_pkg::ACT_TERM,  8'hFF, 1,  1'b1, '{rqr_pkg::STATUS_OK,    8'h00, 1'b0, 5'd16, 5'd0}},
    '{rqr_pkg::ACT_ADD,   8'h00, 1,  1'b1, '{rqr_pkg::STATUS_OK,    8'h00, 1'b0, 5'd0,  5'd1}},
    '{rqr_pkg::ACT_YIELD, 8'hC3, 1,  1'b1, '{rqr_pkg::STATUS_OK,    8'h00, 1'b1, 5'd0,  5'd0}}
  };

  ready_queue_with_remove_unit DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (action),
    .thread_id_i      (thread_id),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .dispatched_id_o  (dispatched_id),
    .dispatch_valid_o (dispatch_valid),
    .removed_count_o  (removed_count),
    .occupancy_o      (occupancy)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Applies one item to the shadow queue and returns the result it gives
  function automatic sched_result_t step_ready_queue(logic [1:0] act,
                                                     logic [IDW-1:0] id);
    sched_result_t       res;
    logic [IDW-1:0]      kept[$];
    res = '{rqr_pkg::STATUS_OK, '0, 1'b0, '0, '0};
    case (act)
      rqr_pkg::ACT_ADD: begin
        if (ready_ids.size() >= rqr_pkg::QUEUE_DEPTH) res.status = rqr_pkg::STATUS_FULL;
        else ready_ids.push_back(id);
      end
      rqr_pkg::ACT_YIELD: begin
        if (ready_ids.size() == 0) begin
          res.status = rqr_pkg::STATUS_EMPTY;
        end else begin
          res.disp_id    = ready_ids.pop_front();
          res.disp_valid = 1'b1;
        end
      end
      rqr_pkg::ACT_TERM: begin
        foreach (ready_ids[i]) begin
          if (ready_ids[i] == id) res.removed++;
          else kept.push_back(ready_ids[i]);
        end
        ready_ids = kept;
      end
      default: ;
    endcase
    res.occupancy = 5'(ready_ids.size());
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(logic [1:0] act, logic [IDW-1:0] id, bit typed,
                           sched_result_t want);
    sched_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    thread_id <= id;
    do @(posedge clk); while (!in_ready);
    res = step_ready_queue(act, id);
    pending_results.push_back(typed ? want : res);
    items_accepted++;
    @(negedge clk);
  endtask

  // Sender holds off until every queued expectation has been matched, then sets the new idle rates
  task automatic drain_and_set_idle(int send_pct, int recv_pct);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    @(negedge clk);
  endtask

  task automatic run_random(int count);
    logic [IDW-1:0]      id_pool[4];
    logic [1:0]          act;
    logic [IDW-1:0]      id;
    int                  add_w;
    int                  r;
    add_w = 50;
    for (int n = 0; n < count; n++) begin
      // new bias and id pool every 64 items, so the queue swings empty to full
      if (n % 64 == 0) begin
        case ($urandom_range(2))
          0: add_w = 25;
          1: add_w = 50;
          default: add_w = 75;
        endcase
        foreach (id_pool[k]) id_pool[k] = IDW'($urandom_range(255));
      end
      r = $urandom_range(99);
      if (r < add_w) act = rqr_pkg::ACT_ADD;
      else if (r < add_w + (95 - add_w) * 2 / 3) act = rqr_pkg::ACT_YIELD;
      else if (r < 95) act = rqr_pkg::ACT_TERM;
      else act = ACT_UNUSED;
      if ($urandom_range(99) < 70) id = id_pool[$urandom_range(3)];
      else id = IDW'($urandom_range(255));
      send_item(act, id, 1'b0, '0);
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    sched_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, status %0d occupancy %0d",
                 $time, status, occupancy);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status);
        check_field("dispatched_id", want.disp_id, dispatched_id);
        check_field("dispatch_valid", want.disp_valid, dispatch_valid);
        check_field("removed_count", want.removed, removed_count);
        check_field("occupancy", want.occupancy, occupancy);
        results_seen++;
        if (want.disp_valid) dispatches++;
        if (want.status == rqr_pkg::STATUS_FULL) full_drops++;
        removals += want.removed;
        if (want.removed > max_removed) max_removed = want.removed;
      end
    end
  end

  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      // one long hold-off while the sender keeps offering items
      if (!long_stall_done && items_accepted >= LONG_STALL_AT) begin
        out_ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(negedge clk);
        long_stall_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    action    = rqr_pkg::ACT_ADD;
    thread_id = '0;
    send_idle_pct = 33;
    recv_idle_pct = 80;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++)
        send_item(directed_rows[r].act, directed_rows[r].id, directed_rows[r].typed,
                  directed_rows[r].want);
    end
    run_random(PHASE_ITEMS);
    drain_and_set_idle(80, 33);
    run_random(PHASE_ITEMS);
    drain_and_set_idle(0, 0);
    run_random(PHASE_ITEMS);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items and %0d results: %0d dispatches, %0d full drops,",
             items_accepted, results_seen, dispatches, full_drops);
    $display("%0d ids removed (at most %0d in one terminate), one %0d-cycle output stall",
             removals, max_removed, LONG_STALL_CYCLES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
